FILE: rtl/fwrp_pkg.sv
// ----------------------------------------------------------------------------
// fwrp_pkg
// Item types, command and status codes, and the microcode program of the
// filtered weighted random pick block.
// ----------------------------------------------------------------------------
package fwrp_pkg;

  localparam int RND_W = 31;
  localparam logic [4:0] RND_MSB = 5'(RND_W - 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_PICK   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [15:0]      entry_id;
    logic [15:0]      entry_difficulty;
    logic [15:0]      entry_weight;
    logic [15:0]      difficulty_limit;
    logic [RND_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] chosen_id;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EXEC,
    S_SUM_INIT,
    S_SUM_LOOP,
    S_SUM_CHECK,
    S_DIV_LOOP,
    S_SEL_INIT,
    S_SEL_LOOP,
    S_SEL_END,
    S_NONE,
    S_EMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_EXEC,
    OP_SUM_INIT,
    OP_SUM_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SEL_INIT,
    OP_SEL_ACC,
    OP_SEL_END,
    OP_SET_NONE,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN,
    C_IS_PICK,
    C_IDX_MORE,
    C_SUM_ZERO,
    C_DIV_MORE,
    C_SEL_MORE,
    C_OUT_BUSY
  } cond_t;

  // jmp is taken when cond holds, nxt otherwise
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  typedef struct packed {
    step_t step;
    uop_t  op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_pick;
    logic idx_more;
    logic sum_zero;
    logic div_more;
    logic sel_more;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:      w = '{OP_ACCEPT,   C_NO_IN,    S_IDLE,     S_DISPATCH};
      S_DISPATCH:  w = '{OP_NOP,      C_IS_PICK,  S_SUM_INIT, S_EXEC};
      S_EXEC:      w = '{OP_EXEC,     C_ALWAYS,   S_EMIT,     S_EMIT};
      S_SUM_INIT:  w = '{OP_SUM_INIT, C_ALWAYS,   S_SUM_LOOP, S_SUM_LOOP};
      S_SUM_LOOP:  w = '{OP_SUM_ACC,  C_IDX_MORE, S_SUM_LOOP, S_SUM_CHECK};
      S_SUM_CHECK: w = '{OP_DIV_INIT, C_SUM_ZERO, S_NONE,     S_DIV_LOOP};
      S_DIV_LOOP:  w = '{OP_DIV_STEP, C_DIV_MORE, S_DIV_LOOP, S_SEL_INIT};
      S_SEL_INIT:  w = '{OP_SEL_INIT, C_ALWAYS,   S_SEL_LOOP, S_SEL_LOOP};
      S_SEL_LOOP:  w = '{OP_SEL_ACC,  C_SEL_MORE, S_SEL_LOOP, S_SEL_END};
      S_SEL_END:   w = '{OP_SEL_END,  C_ALWAYS,   S_EMIT,     S_EMIT};
      S_NONE:      w = '{OP_SET_NONE, C_ALWAYS,   S_EMIT,     S_EMIT};
      S_EMIT:      w = '{OP_EMIT,     C_OUT_BUSY, S_EMIT,     S_IDLE};
      default:     w = '{OP_NOP,      C_ALWAYS,   S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/fwrp_ucode.sv
// ----------------------------------------------------------------------------
// fwrp_ucode
// Step counter and control store; evaluates the jump condition of each word.
// ----------------------------------------------------------------------------
module fwrp_ucode (
  input  logic            clk,
  input  logic            rst_n,
  input  fwrp_pkg::flags_t flags,
  output fwrp_pkg::ctrl_t  ctrl
);
  import fwrp_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  uword_t word;
  logic   taken;

  always_comb begin
    word = ucode_rom(pc_r);
    unique case (word.cond)
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = !flags.in_valid;
      C_IS_PICK:  taken = flags.is_pick;
      C_IDX_MORE: taken = flags.idx_more;
      C_SUM_ZERO: taken = flags.sum_zero;
      C_DIV_MORE: taken = flags.div_more;
      C_SEL_MORE: taken = flags.sel_more;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
    pc_nxt = taken ? word.jmp : word.nxt;
  end

  assign ctrl.step = pc_r;
  assign ctrl.op   = word.op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/fwrp_datapath.sv
// ----------------------------------------------------------------------------
// fwrp_datapath
// Entry table, eligible weight sum, bit-serial modulo and select walk,
// driven by the micro-op of the current step.
// ----------------------------------------------------------------------------
module fwrp_datapath #(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fwrp_pkg::ctrl_t     ctrl,
  input  logic                in_valid,
  output logic                in_stall,
  input  fwrp_pkg::in_item_t  in_data,
  input  logic                out_busy,
  output fwrp_pkg::flags_t    flags,
  output logic                res_valid,
  output fwrp_pkg::out_item_t res_data
);
  import fwrp_pkg::*;

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int SUM_W = WB + CW;
  localparam logic [CW-1:0] CMAX = CW'(MAX_ENTRIES);

  typedef struct packed {
    logic [15:0]   id;
    logic [15:0]   diff;
    logic [WB-1:0] weight;
  } ent_t;

  ent_t mem [MAX_ENTRIES];
  ent_t rd_r;
  logic wr_en;

  in_item_t         item_r, item_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [RND_W-1:0] rem_r, rem_nxt;
  logic [4:0]       div_cnt_r, div_cnt_nxt;
  logic             hit_r, hit_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      chosen_r, chosen_nxt;

  logic             elig;
  logic             idx_more;
  logic [SUM_W-1:0] w_ext;
  logic [SUM_W-1:0] run_nxt;
  logic             hit_now;
  logic [31:0]      rem_sh;
  logic [31:0]      acc_32;

  assign in_stall = (ctrl.op != OP_ACCEPT);

  assign elig     = (rd_r.diff <= item_r.difficulty_limit);
  assign idx_more = (idx_r != count_r);
  assign w_ext    = SUM_W'(rd_r.weight);
  assign run_nxt  = acc_r + w_ext;
  assign hit_now  = (32'(run_nxt) > 32'(rem_r));
  assign rem_sh   = {rem_r, item_r.random_value[div_cnt_r]};
  assign acc_32   = 32'(acc_r);

  always_comb begin
    item_nxt    = item_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    hit_nxt     = hit_r;
    status_nxt  = status_r;
    chosen_nxt  = chosen_r;
    wr_en       = 1'b0;
    res_valid   = 1'b0;
    unique case (ctrl.op)
      OP_NOP: begin
      end
      OP_ACCEPT: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      OP_EXEC: begin
        status_nxt = ST_OK;
        chosen_nxt = '0;
        if (item_r.command == CMD_CLEAR) begin
          count_nxt = '0;
        end else if (item_r.command == CMD_APPEND) begin
          if (count_r < CMAX) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            status_nxt = ST_FULL;
          end
        end
      end
      OP_SUM_INIT: begin
        idx_nxt = '0;
        acc_nxt = '0;
      end
      OP_SUM_ACC: begin
        if (idx_more) begin
          idx_nxt = idx_r + 1'b1;
          if (elig) begin
            acc_nxt = run_nxt;
          end
        end
      end
      OP_DIV_INIT: begin
        rem_nxt     = '0;
        div_cnt_nxt = RND_MSB;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= acc_32) begin
          rem_nxt = RND_W'(rem_sh - acc_32);
        end else begin
          rem_nxt = rem_sh[RND_W-1:0];
        end
        if (div_cnt_r != '0) begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      OP_SEL_INIT: begin
        idx_nxt    = '0;
        acc_nxt    = '0;
        hit_nxt    = 1'b0;
        chosen_nxt = '0;
      end
      OP_SEL_ACC: begin
        if (idx_more && !hit_r) begin
          idx_nxt = idx_r + 1'b1;
          if (elig) begin
            acc_nxt = run_nxt;
            if (hit_now) begin
              hit_nxt    = 1'b1;
              chosen_nxt = rd_r.id;
            end
          end
        end
      end
      OP_SEL_END: begin
        status_nxt = hit_r ? ST_OK : ST_NONE;
      end
      OP_SET_NONE: begin
        status_nxt = ST_NONE;
        chosen_nxt = '0;
      end
      OP_EMIT: begin
        res_valid = !out_busy;
      end
      default: begin
      end
    endcase
  end

  assign res_data.status    = status_r;
  assign res_data.chosen_id = chosen_r;

  assign flags.in_valid = in_valid;
  assign flags.is_pick  = (item_r.command == CMD_PICK);
  assign flags.idx_more = idx_more;
  assign flags.sum_zero = (acc_r == '0);
  assign flags.div_more = (div_cnt_r != '0);
  assign flags.sel_more = idx_more && !hit_r;
  assign flags.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= '{id: item_r.entry_id, diff: item_r.entry_difficulty,
                                weight: item_r.entry_weight[WB-1:0]};
    end
    rd_r <= mem[idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    chosen_r  <= chosen_nxt;
  end

endmodule

FILE: rtl/filtered_weighted_random_pick.sv
// ----------------------------------------------------------------------------
// filtered_weighted_random_pick
// Roulette wheel selection over a table of entries filtered by difficulty.
// Clear and append are executed directly from the accepted item. Pick runs a
// sum walk over the N stored entries, a 31-step modulo and a select walk.
// One item at a time; the next item is taken while a result waits in the
// output register. Synchronous reset empties the table, no clearing pass.
// ----------------------------------------------------------------------------
module filtered_weighted_random_pick #(
  parameter int MAX_ENTRIES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fwrp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fwrp_pkg::out_item_t out_data
);
  import fwrp_pkg::*;

  ctrl_t     ctrl;
  flags_t    flags;
  logic      res_valid;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_busy;

  assign out_busy = out_valid_r && out_stall;

  fwrp_ucode u_ucode (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  fwrp_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_busy  (out_busy),
    .flags     (flags),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ctrl.step == S_DISPATCH)
    else $error("accepted item did not start a program");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> ctrl.step == S_IDLE)
    else $error("input taken outside idle step");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.step == S_EMIT))
    else $error("result appeared outside emit step");

  a_none_has_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NONE || out_data.status == ST_FULL)
      |-> out_data.chosen_id == '0)
    else $error("nonzero id without a pick");

endmodule
